@@ sv/afr_pkg.sv @@
// Shared constants, codes and controller/datapath link types of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package afr_pkg;

   // Frame buffer geometry
   localparam int BUF_DEPTH = 64;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int LIM_W     = $clog2(BUF_DEPTH + 1);

   // Frame format
   localparam logic [7:0] START_BYTE  = 8'h7E;
   localparam logic [7:0] CSUM_TARGET = 8'hFF;
   localparam int         HDR_BYTES   = 5;   // API id, source hi, source lo, rssi, options
   localparam int         TX_MIN_LEN  = 3;   // status byte present from this length on

   // Result kinds
   localparam logic [1:0] KIND_TX_OK  = 2'd0;
   localparam logic [1:0] KIND_TX_ERR = 2'd1;
   localparam logic [1:0] KIND_RX     = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_TX_CODE = 2'd0;
   localparam logic [1:0] REG_RX_CODE = 2'd1;
   localparam logic [1:0] REG_MAX_LEN = 2'd2;
   localparam logic [1:0] REG_DELIVER = 2'd3;

   // Register reset values
   localparam logic [7:0] TX_CODE_RST = 8'd137;
   localparam logic [7:0] RX_CODE_RST = 8'd129;
   localparam logic [6:0] MAX_LEN_RST = 7'd64;

   typedef struct packed {
      logic start_frame;  // start byte taken, clear the sum
      logic load_len_hi;
      logic load_len_lo;
      logic store_data;   // frame data byte taken
      logic start_emit;   // good frame closed, latch result setup
      logic read_mem;     // fetch the current payload byte
      logic load_out;     // fill the result register
      logic next_item;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic len_ok;
      logic at_checksum;
      logic frame_good;   // checksum matches and the frame gives results
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

@@ sv/afr_req_if.sv @@
// Input byte channel of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ sv/afr_rsp_if.sv @@
// Result channel of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
interface afr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] source_addr;
   logic [7:0]  rssi;
   logic [7:0]  frame_options;
   logic [7:0]  payload_byte;
   logic [5:0]  payload_index;
   logic [5:0]  payload_count;
   logic        byte_valid;
   logic        last;

   modport source (output valid, output kind, output source_addr, output rssi,
                   output frame_options, output payload_byte, output payload_index,
                   output payload_count, output byte_valid, output last, input ready);
   modport sink   (input valid, input kind, input source_addr, input rssi,
                   input frame_options, input payload_byte, input payload_index,
                   input payload_count, input byte_valid, input last, output ready);
endinterface
`default_nettype wire

@@ sv/afr_ctrl.sv @@
// Controller state machine of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module afr_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  afr_pkg::sts_type  sts,
   output afr_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_HUNT   = 6'b000001,
      ST_LEN_HI = 6'b000010,
      ST_LEN_LO = 6'b000100,
      ST_DATA   = 6'b001000,
      ST_READ   = 6'b010000,
      ST_LOAD   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign req_ready = (state_ff == ST_HUNT) || (state_ff == ST_LEN_HI) ||
                      (state_ff == ST_LEN_LO) || (state_ff == ST_DATA);
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_HUNT: begin
            if (take && sts.is_start) begin
               cmd.start_frame = 1'b1;
               state_in        = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            if (take) begin
               cmd.load_len_hi = 1'b1;
               state_in        = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (take) begin
               cmd.load_len_lo = 1'b1;
               state_in        = sts.len_ok ? ST_DATA : ST_HUNT;
            end
         end
         ST_DATA: begin
            if (take) begin
               if (!sts.at_checksum) begin
                  cmd.store_data = 1'b1;
               end else if (sts.frame_good) begin
                  cmd.start_emit = 1'b1;
                  state_in       = ST_READ;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_READ: begin
            cmd.read_mem = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.next_item = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/afr_datapath.sv @@
// Datapath of the frame receiver: registers, length and sum, frame buffer, result register.
`timescale 1ns / 1ps
`default_nettype none
module afr_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  afr_pkg::cmd_type           cmd,
   output afr_pkg::sts_type           sts,
   input  wire  [7:0]                 rx_byte,
   input  wire                        csr_we,
   input  wire  [1:0]                 csr_index,
   input  wire  [7:0]                 csr_wdata,
   afr_rsp_if.source                  rsp
);

   // Configuration
   logic [7:0] tx_code_ff;
   logic [7:0] rx_code_ff;
   logic [6:0] max_len_ff;
   logic       deliver_ff;

   // Frame reception
   logic [7:0]                 len_hi_ff;
   logic [afr_pkg::LIM_W-1:0]  len_ff;
   logic [afr_pkg::LIM_W-1:0]  idx_ff;
   logic [7:0]                 sum_ff;
   logic [7:0]                 hdr_ff [afr_pkg::HDR_BYTES];
   logic [7:0]                 mem [afr_pkg::BUF_DEPTH];
   logic [7:0]                 rd_data_ff;

   // Result sequencing
   logic       emit_tx_ff;
   logic       tx_ok_ff;
   logic [5:0] count_ff;
   logic [5:0] item_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [15:0] src_ff;
   logic [7:0]  rssi_ff;
   logic [7:0]  opts_ff;
   logic [7:0]  pbyte_ff;
   logic [5:0]  pidx_ff;
   logic [5:0]  pcnt_ff;
   logic        bvalid_ff;
   logic        last_ff;

   logic [afr_pkg::LIM_W-1:0]  limit;
   logic [15:0]                len_full;
   logic [7:0]                 sum_next;
   logic                       is_tx;
   logic                       is_rx;
   logic [afr_pkg::BUF_AW-1:0] rd_addr;
   logic                       has_bytes;

   assign limit = (32'(max_len_ff) < afr_pkg::BUF_DEPTH) ? afr_pkg::LIM_W'(max_len_ff)
                                                         : afr_pkg::LIM_W'(afr_pkg::BUF_DEPTH);
   assign len_full = {len_hi_ff, rx_byte};
   assign sum_next = sum_ff + rx_byte;
   assign is_tx    = (hdr_ff[0] == tx_code_ff);
   assign is_rx    = (hdr_ff[0] == rx_code_ff) && deliver_ff &&
                     (len_ff >= afr_pkg::LIM_W'(afr_pkg::HDR_BYTES));
   assign rd_addr  = afr_pkg::BUF_AW'(item_ff) + afr_pkg::BUF_AW'(afr_pkg::HDR_BYTES);
   assign has_bytes = (count_ff != 6'd0);

   assign sts.is_start    = (rx_byte == afr_pkg::START_BYTE);
   assign sts.len_ok      = (len_full <= 16'(limit));
   assign sts.at_checksum = (idx_ff == len_ff);
   assign sts.frame_good  = (sum_next == afr_pkg::CSUM_TARGET) &&
                            (len_ff != '0) && (is_tx || is_rx);
   assign sts.emit_last   = emit_tx_ff || !has_bytes || (item_ff == count_ff - 6'd1);
   assign sts.out_free    = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_code_ff <= afr_pkg::TX_CODE_RST;
         rx_code_ff <= afr_pkg::RX_CODE_RST;
         max_len_ff <= afr_pkg::MAX_LEN_RST;
         deliver_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            afr_pkg::REG_TX_CODE: tx_code_ff <= csr_wdata;
            afr_pkg::REG_RX_CODE: rx_code_ff <= csr_wdata;
            afr_pkg::REG_MAX_LEN: max_len_ff <= csr_wdata[6:0];
            afr_pkg::REG_DELIVER: deliver_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
         len_ff <= '0;
      end else begin
         if (cmd.start_frame) begin
            sum_ff <= '0;
         end else if (cmd.store_data) begin
            sum_ff <= sum_next;
         end
         if (cmd.load_len_lo) begin
            len_ff <= afr_pkg::LIM_W'(len_full);
            idx_ff <= '0;
         end else if (cmd.store_data) begin
            idx_ff <= idx_ff + afr_pkg::LIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_len_hi) begin
         len_hi_ff <= rx_byte;
      end
   end

   // Header bytes also kept in flops so they can be read alongside the payload
   for (genvar k = 0; k < afr_pkg::HDR_BYTES; k++) begin : g_hdr
      always_ff @(posedge clock) begin
         if (cmd.store_data && (idx_ff == afr_pkg::LIM_W'(k))) begin
            hdr_ff[k] <= rx_byte;
         end
      end
   end

   // Frame buffer
   always_ff @(posedge clock) begin
      if (cmd.store_data) begin
         mem[idx_ff[afr_pkg::BUF_AW-1:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_mem) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_emit) begin
         emit_tx_ff <= is_tx;
         tx_ok_ff   <= (len_ff >= afr_pkg::LIM_W'(afr_pkg::TX_MIN_LEN)) && (hdr_ff[2] == 8'd0);
         count_ff   <= 6'(len_ff - afr_pkg::LIM_W'(afr_pkg::HDR_BYTES));
         item_ff    <= '0;
      end else if (cmd.next_item) begin
         item_ff <= item_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         last_ff <= sts.emit_last;
         if (emit_tx_ff) begin
            kind_ff   <= tx_ok_ff ? afr_pkg::KIND_TX_OK : afr_pkg::KIND_TX_ERR;
            src_ff    <= '0;
            rssi_ff   <= '0;
            opts_ff   <= '0;
            pbyte_ff  <= '0;
            pidx_ff   <= '0;
            pcnt_ff   <= '0;
            bvalid_ff <= 1'b0;
         end else begin
            kind_ff   <= afr_pkg::KIND_RX;
            src_ff    <= {hdr_ff[1], hdr_ff[2]};
            rssi_ff   <= hdr_ff[3];
            opts_ff   <= hdr_ff[4];
            pbyte_ff  <= has_bytes ? rd_data_ff : 8'd0;
            pidx_ff   <= has_bytes ? item_ff : 6'd0;
            pcnt_ff   <= count_ff;
            bvalid_ff <= has_bytes;
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.source_addr   = src_ff;
   assign rsp.rssi          = rssi_ff;
   assign rsp.frame_options = opts_ff;
   assign rsp.payload_byte  = pbyte_ff;
   assign rsp.payload_index = pidx_ff;
   assign rsp.payload_count = pcnt_ff;
   assign rsp.byte_valid    = bvalid_ff;
   assign rsp.last          = last_ff;

endmodule
`default_nettype wire

@@ sv/api_frame_receiver.sv @@
// Top level of the serial API frame receiver: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir   Handshake           Carries
// req_chan  in    valid/ready         rx_byte, one link byte per item
// rsp_chan  out   valid/ready         kind, source, rssi, options, payload byte/index/count,
//                                     byte_valid, last
// csr_*     in    csr_we (no stall)   csr_index selects register, csr_wdata is the value
//
// Bytes of a frame are taken one per cycle. After a good checksum byte the input is
// held off while results go out, each by a buffer read and then a result load, the
// load waiting while the output register still holds a result the sink has not taken.
// The last result waits in the output register while the next bytes come in. Reset
// is synchronous and leaves the receiver hunting for the start byte with registers at
// their defaults; the buffer needs no clearing.
module api_frame_receiver (
   input  wire        clock,
   input  wire        reset,
   afr_req_if.sink    req_chan,
   afr_rsp_if.source  rsp_chan,
   input  wire        csr_we,
   input  wire  [1:0] csr_index,
   input  wire  [7:0] csr_wdata
);

   afr_pkg::cmd_type cmd;
   afr_pkg::sts_type sts;

   // Sequencing: hunt, length bytes, data/checksum, then result read/load loop
   afr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, checksum, configuration and the result register
   afr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .rx_byte   (req_chan.rx_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire
